// File: sv/fmm_pkg.sv
// Shared types, constants and the arctangent table of the FM baseband modulator.
package fmm_pkg;

  // Register and default parameter values
  localparam int unsigned FMM_GAIN_W        = 31;
  localparam logic [30:0] FMM_GAIN_RESET    = 31'd447392427;
  localparam int unsigned FMM_PHASE_BITS    = 32;
  localparam int unsigned FMM_SAMPLE_BITS   = 16;
  localparam int unsigned FMM_OUT_BITS      = 16;
  localparam int unsigned FMM_CORDIC_STAGES = 16;
  localparam int unsigned FMM_MAX_STAGES    = 24;

  // CORDIC datapath: 32-bit angle in turns, Q30 vectors, two guard bits
  localparam int unsigned FMM_ANG_W = 32;
  localparam int unsigned FMM_VEC_W = 34;

  localparam logic signed [FMM_VEC_W-1:0] FMM_KINF    = 34'sd652032874;
  localparam logic signed [FMM_VEC_W-1:0] FMM_QUARTER = 34'sd1073741824;
  localparam logic signed [FMM_VEC_W-1:0] FMM_HALF    = 34'sd2147483648;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [FMM_ANG_W-1:0] FMM_ATAN_TURNS [FMM_MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // One item in flight through the rotator
  typedef struct packed {
    logic                        valid;
    logic                        neg;
    logic signed [FMM_VEC_W-1:0] x;
    logic signed [FMM_VEC_W-1:0] y;
    logic signed [FMM_VEC_W-1:0] z;
  } fmm_vec_t;

endpackage

// File: sv/fmm_phase.sv
// Deviation multiply, phase accumulator and half-plane fold ahead of the CORDIC row.
module fmm_phase #(
  parameter int unsigned PHASE_BITS  = fmm_pkg::FMM_PHASE_BITS,
  parameter int unsigned SAMPLE_BITS = fmm_pkg::FMM_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic [fmm_pkg::FMM_GAIN_W-1:0]      gain_i,
  output fmm_pkg::fmm_vec_t                   vec_o
);

  localparam int unsigned PW    = SAMPLE_BITS + 32;
  localparam int unsigned EXT_W = (PHASE_BITS > PW) ? PHASE_BITS : PW;

  logic signed [31:0]                   gain_s;
  logic signed [PW-1:0]                 prod_d, prod_q;
  logic                                 v0_q;
  logic signed [PW-1:0]                 step_full;
  logic signed [EXT_W-1:0]              step_ext;
  logic [PHASE_BITS-1:0]                phase_d, phase_q;
  logic [fmm_pkg::FMM_ANG_W-1:0]        ang;
  logic signed [fmm_pkg::FMM_VEC_W-1:0] z_raw;
  fmm_pkg::fmm_vec_t                    vec_d, vec_q;

  assign gain_s = $signed({1'b0, gain_i});
  assign prod_d = PW'(sample_i) * PW'(gain_s);

  // Floor shift of the exact product, then modulo-one-turn add
  assign step_full = prod_q >>> (SAMPLE_BITS - 1);
  assign step_ext  = EXT_W'(step_full);
  assign phase_d   = phase_q + step_ext[PHASE_BITS-1:0];

  generate
    if (PHASE_BITS >= fmm_pkg::FMM_ANG_W) begin : g_ang_top
      assign ang = phase_d[PHASE_BITS-1 -: fmm_pkg::FMM_ANG_W];
    end else begin : g_ang_shl
      assign ang = {phase_d, (fmm_pkg::FMM_ANG_W - PHASE_BITS)'(0)};
    end
  endgenerate

  assign z_raw = {{2{ang[fmm_pkg::FMM_ANG_W-1]}}, ang};

  always_comb begin
    vec_d.valid = v0_q;
    vec_d.x     = fmm_pkg::FMM_KINF;
    vec_d.y     = '0;
    vec_d.neg   = 1'b0;
    vec_d.z     = z_raw;
    if (z_raw > fmm_pkg::FMM_QUARTER) begin
      vec_d.z   = z_raw - fmm_pkg::FMM_HALF;
      vec_d.neg = 1'b1;
    end else if (z_raw < -fmm_pkg::FMM_QUARTER) begin
      vec_d.z   = z_raw + fmm_pkg::FMM_HALF;
      vec_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      phase_q     <= '0;
      vec_q.valid <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      if (v0_q) begin
        phase_q <= phase_d;
      end
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// File: sv/fmm_cordic_cell.sv
// One CORDIC rotation cell: a fixed shift, a table angle and a register.
module fmm_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fmm_pkg::fmm_vec_t vec_i,
  output fmm_pkg::fmm_vec_t vec_o
);

  logic signed [fmm_pkg::FMM_VEC_W-1:0] x, y, z, dx, dy, at;
  fmm_pkg::fmm_vec_t                    vec_d, vec_q;

  assign x  = vec_i.x;
  assign y  = vec_i.y;
  assign z  = vec_i.z;
  assign dx = y >>> STAGE;
  assign dy = x >>> STAGE;
  assign at = $signed({2'b00, fmm_pkg::FMM_ATAN_TURNS[STAGE]});

  always_comb begin
    vec_d.valid = vec_i.valid;
    vec_d.neg   = vec_i.neg;
    if (!z[fmm_pkg::FMM_VEC_W-1]) begin
      vec_d.x = x - dx;
      vec_d.y = y + dy;
      vec_d.z = z - at;
    end else begin
      vec_d.x = x + dx;
      vec_d.y = y - dy;
      vec_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q.valid <= 1'b0;
    end else if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

// File: sv/fmm_scale.sv
// Q30 to output format: scale by full scale, round, saturate and undo the fold.
module fmm_scale #(
  parameter int unsigned OUT_BITS = fmm_pkg::FMM_OUT_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  fmm_pkg::fmm_vec_t          vec_i,
  output logic                       valid_o,
  output logic [OUT_BITS-1:0]        in_phase_o,
  output logic [OUT_BITS-1:0]        quadrature_o
);

  localparam int unsigned MW = fmm_pkg::FMM_VEC_W + OUT_BITS + 1;
  localparam logic signed [OUT_BITS:0] MAXV =
    $signed((OUT_BITS+1)'((64'd1 << (OUT_BITS - 1)) - 64'd1));
  localparam logic signed [MW-1:0] MAXV_W = MW'(MAXV);
  localparam logic signed [MW-1:0] RND    = MW'(64'd1 << 29);

  logic signed [MW-1:0] px_d, py_d, px_q, py_q;
  logic                 neg_q, valid_q;

  function automatic logic [OUT_BITS-1:0] round_sat(input logic signed [MW-1:0] p,
                                                    input logic neg);
    logic signed [MW-1:0] r;
    r = (p + RND) >>> 30;
    if (r > MAXV_W) begin
      r = MAXV_W;
    end else if (r < -MAXV_W) begin
      r = -MAXV_W;
    end
    if (neg) begin
      r = -r;
    end
    return OUT_BITS'(r);
  endfunction

  assign px_d = MW'(vec_i.x) * MAXV_W;
  assign py_d = MW'(vec_i.y) * MAXV_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      neg_q <= vec_i.neg;
    end
  end

  assign valid_o      = valid_q;
  assign in_phase_o   = round_sat(px_q, neg_q);
  assign quadrature_o = round_sat(py_q, neg_q);

endmodule

// File: sv/fm_baseband_modulator_top.sv
// Top level of the FM baseband modulator: phase accumulator, CORDIC row, output buffer.
//
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/tready         sample (signed Q1.15)
// m_axis   out  m_axis_tvalid/tready         in_phase, quadrature (signed Q1.15)
// cfg      in   cfg_valid/cfg_ready          deviation_gain (31 bits)
//
// One item per cycle sustained while the skid register is free. From acceptance
// to m_axis_tvalid an item passes the deviation multiply, accumulate and fold,
// one register per CORDIC cell, output scaling multiply and output register.
// Reset clears the phase to zero and loads the default gain.
// The whole pipe advances together; a stalled output item parks in a skid
// register, and only a full skid holds off s_axis_tready (registered, so
// the input side never depends on m_axis_tready in the same cycle).
module fm_baseband_modulator_top #(
  parameter int unsigned PHASE_BITS    = fmm_pkg::FMM_PHASE_BITS,
  parameter int unsigned SAMPLE_BITS   = fmm_pkg::FMM_SAMPLE_BITS,
  parameter int unsigned OUT_BITS      = fmm_pkg::FMM_OUT_BITS,
  parameter int unsigned CORDIC_STAGES = fmm_pkg::FMM_CORDIC_STAGES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata: in_phase, quadrature
  output logic [((2*OUT_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fmm_pkg::FMM_GAIN_W-1:0]        cfg_data_i
);

  localparam int unsigned M_TW = ((2*OUT_BITS+7)/8)*8;
  localparam int unsigned DW   = 2 * OUT_BITS;

  logic [fmm_pkg::FMM_GAIN_W-1:0] gain_q;
  logic                           en;
  logic                           arrive;
  logic                           scale_valid;
  logic [OUT_BITS-1:0]            in_phase, quadrature;
  logic [DW-1:0]                  new_data;
  logic                           out_valid_q, skid_valid_q;
  logic [DW-1:0]                  out_data_q, skid_data_q;
  fmm_pkg::fmm_vec_t              chain [CORDIC_STAGES+1];

  // Gain register; the user must write it only while the block is idle (not enforced)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= fmm_pkg::FMM_GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // Pipe moves whenever the skid is free
  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;

  fmm_phase #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .sample_i ($signed(s_axis_tdata_i[SAMPLE_BITS-1:0])),
    .gain_i   (gain_q),
    .vec_o    (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fmm_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vec_i  (chain[g]),
      .vec_o  (chain[g+1])
    );
  end

  fmm_scale #(
    .OUT_BITS (OUT_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vec_i        (chain[CORDIC_STAGES]),
    .valid_o      (scale_valid),
    .in_phase_o   (in_phase),
    .quadrature_o (quadrature)
  );

  assign arrive   = scale_valid && en;
  assign new_data = {quadrature, in_phase};

  // Output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !m_axis_tready_i) begin
      if (arrive) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= arrive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !m_axis_tready_i) begin
      if (arrive) begin
        skid_data_q <= new_data;
      end
    end else if (skid_valid_q) begin
      out_data_q <= skid_data_q;
    end else if (arrive) begin
      out_data_q <= new_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TW'(out_data_q);

endmodule

// File: dv/tb_fm_baseband_modulator_top.sv
// Self-checking testbench of the FM baseband modulator: bit-exact I/Q prediction per sample.
module tb_fm_baseband_modulator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fmm_pkg::*;

  // Extra drain time after the last predicted item has come out.
  localparam int LATENCY     = FMM_CORDIC_STAGES + 8;
  // Watchdog limit on the length of the whole run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int BATCH_ITEMS = 200;
  localparam int NUM_BATCHES = 8;

  localparam logic [FMM_GAIN_W-1:0] GAIN_MAX     = '1;
  localparam logic [FMM_GAIN_W-1:0] GAIN_QUARTER = 31'd1073741824;

  // One output item, in_phase in the low half of tdata.
  typedef struct packed {
    logic signed [15:0] quadrature;
    logic signed [15:0] in_phase;
  } iq_t;

  // Sender and receiver pacing modes
  typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;

  // ---------------------------------------------------------------------------
  // Tracks gain and phase, predicts I/Q per accepted sample, checks results.
  // ---------------------------------------------------------------------------
  class fm_iq_tracker;
    logic [FMM_GAIN_W-1:0] gain;
    logic [31:0]           phase;
    iq_t                   pending_iq[$];
    int                    errors;

    function new();
      gain   = FMM_GAIN_RESET;
      phase  = '0;
      errors = 0;
    endfunction

    function void set_gain(logic [FMM_GAIN_W-1:0] value);
      gain = value;
    endfunction

    // Round Q30 to the output width, saturate to +-max, undo the fold.
    function logic [15:0] scale_q30(longint v, bit fold);
      longint maxv;
      longint r;
      maxv = 32767;
      r = (v * maxv + (longint'(1) <<< 29)) >>> 30;
      if (r > maxv) r = maxv;
      if (r < -maxv) r = -maxv;
      if (fold) r = -r;
      return r[15:0];
    endfunction

    // Accumulate phase and rotate (Kinf, 0) by it.
    function iq_t advance_phase(logic signed [15:0] sample);
      longint step;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint qturn;
      bit     fold;
      int     i;
      iq_t    r;
      step  = (longint'(sample) * longint'(gain)) >>> (FMM_SAMPLE_BITS - 1);
      phase = phase + step[31:0];
      qturn = longint'(1) <<< 30;
      z     = longint'($signed(phase));
      fold  = 1'b0;
      // half-plane fold: beyond a quarter turn, rotate by half a turn
      if (z > qturn) begin
        z    = z - (qturn <<< 1);
        fold = 1'b1;
      end else if (z < -qturn) begin
        z    = z + (qturn <<< 1);
        fold = 1'b1;
      end
      x = longint'(FMM_KINF);
      y = 0;
      for (i = 0; i < FMM_CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(FMM_ATAN_TURNS[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(FMM_ATAN_TURNS[i]);
        end
      end
      r.in_phase   = scale_q30(x, fold);
      r.quadrature = scale_q30(y, fold);
      return r;
    endfunction

    function void note_sample(logic signed [15:0] sample);
      pending_iq.push_back(advance_phase(sample));
    endfunction

    function void check_result(iq_t got);
      iq_t want;
      if (pending_iq.size() == 0) begin
        $error("unexpected output item: in_phase %0d quadrature %0d",
               got.in_phase, got.quadrature);
        errors++;
        return;
      end
      want = pending_iq.pop_front();
      if (got.in_phase !== want.in_phase) begin
        $error("in_phase: expected %0d, got %0d", want.in_phase, got.in_phase);
        errors++;
      end
      if (got.quadrature !== want.quadrature) begin
        $error("quadrature: expected %0d, got %0d", want.quadrature, got.quadrature);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [15:0]           s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [31:0]           m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [FMM_GAIN_W-1:0] cfg_data_i      = '0;

  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;
  int            cycles         = 0;
  fm_iq_tracker  tracker        = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fm_baseband_modulator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Receiver: random stalls applied at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Output monitor: an item moves at a rising edge with valid and ready high
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_result(iq_t'(m_axis_tdata_o));
    end
  end

  // Watchdog: a hung handshake or a lost item ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Each task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  function void set_pace(pace_e mode);
    src_idle_pct   = (mode == PACE_SRC_IDLE)   ? 61 : (mode == PACE_BOTH) ? 24 : 0;
    sink_stall_pct = (mode == PACE_SINK_STALL) ? 61 : (mode == PACE_BOTH) ? 24 : 0;
  endfunction

  // Offer one sample, with random idle cycles ahead of it. tvalid stays high
  // on return so back-to-back items need no extra assignment.
  task automatic send_sample(input logic [15:0] sample);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = sample;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_sample(sample);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid_i = 1'b0;
  endtask

  // Gain write; only called with the pipe empty
  task automatic write_gain(input logic [FMM_GAIN_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_gain(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Wait until every predicted item has come out, then let the pipe drain.
  task automatic drain(input int extra);
    while (tracker.pending_iq.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly full-range samples, some extremes, some small values.
  function automatic logic [15:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(4))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        3:       return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    if (roll < 30) return 16'($signed($urandom_range(512)) - 256);
    return 16'($urandom);
  endfunction

  function automatic logic [FMM_GAIN_W-1:0] pick_gain(int batch);
    case (batch)
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return FMM_GAIN_RESET;
      4:       return FMM_GAIN_W'($urandom_range(65535));
      5:       return FMM_GAIN_W'(1);
      7:       return GAIN_MAX;
      default: return FMM_GAIN_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] edge_samples[9];
    int          b;
    int          k;

    edge_samples = '{16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                     16'h0001, 16'hffff, 16'h5555, 16'haaaa};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, default gain: sample extremes and alternating bit patterns.
    set_pace(PACE_FREE);
    foreach (edge_samples[k]) send_sample(edge_samples[k]);
    end_burst();
    drain(LATENCY);

    // Quarter-turn gain: 16384 steps the phase by an eighth of a turn, so the
    // angle moves in eighth-turn steps across the fold boundaries at +-1/4 turn.
    write_gain(GAIN_QUARTER);
    for (k = 0; k < 8; k++) send_sample(16'sd16384);
    for (k = 0; k < 4; k++) send_sample(-16'sd16384);
    end_burst();
    drain(LATENCY);

    // Random batches, one gain setting and one pacing mode each.
    for (b = 0; b < NUM_BATCHES; b++) begin
      write_gain(pick_gain(b));
      set_pace(pace_e'(b % 4));
      for (k = 0; k < BATCH_ITEMS; k++) send_sample(pick_sample());
      end_burst();
      drain(LATENCY);
    end

    set_pace(PACE_FREE);
    drain(2 * LATENCY);

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: fm_baseband_modulator_top.f
sv/fmm_pkg.sv
sv/fmm_phase.sv
sv/fmm_cordic_cell.sv
sv/fmm_scale.sv
sv/fm_baseband_modulator_top.sv
dv/tb_fm_baseband_modulator_top.sv
